@@ hw/rtl/pwmt_pkg.sv @@
// shared types and constants of the four channel pwm timer
// no dependencies
package pwmt_pkg;

    localparam int CHANNELS    = 4;
    localparam int CNT_W       = 16;
    localparam int CMP_W       = CNT_W + 1;
    localparam int DUTY_W      = 14;
    localparam int CH_W        = 2;
    localparam int PROD_W      = DUTY_W + CMP_W;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 32;
    localparam int SCALED_W    = PROD_W + RECIP_W;

    localparam logic [DUTY_W-1:0]  DUTY_FULL      = 14'd10000;
    // floor(2^32 / 10000)
    localparam logic [RECIP_W-1:0] DUTY_RECIP     = 19'd429496;
    localparam logic [CNT_W-1:0]   PRESCALE_RESET = 16'd71;
    localparam logic [CNT_W-1:0]   PERIOD_RESET   = 16'd999;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_DUTY   = 2'd1,
        MODE_ENABLE = 2'd2
    } mode_t;

    typedef enum logic [0:0] {
        CFG_PRESCALE = 1'b0,
        CFG_PERIOD   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        mode_t            mode;
        logic [CH_W-1:0]  channel;
        logic             enable;
    } item_t;

endpackage

@@ hw/rtl/four_channel_pwm_timer.sv @@
// four channel edge aligned pwm timer, pwm mode 1
// depends on pwmt_pkg
//
// usage:
//   s_* carries one request per item: s_tuser is the mode (tick, duty, enable),
//   s_tdata holds channel, duty and enable. every accepted request gives
//   exactly one result on m_*: channel levels, counter value and update flag.
//   cfg_we/cfg_index/cfg_data write prescale_limit (index 0) and
//   period_limit (index 1); write only while the timer is idle.
// pipeline: four stages compute the compare value (duty product, reciprocal
//   multiply, remainder correction); the fifth applies the request to the timer
//   state and loads the output register.
// throughput: one request per cycle unless m_tready stalls the output; the multipliers
//   are pipelined so the timer state is touched at most once per cycle in request order.
// reset: counters and compares clear, all channels off, limits return to
//   71 and 999, the pipeline empties.
// stall: while m_tready is low the result holds; the stages behind it keep
//   filling, and s_tready drops only once all of them are full.
module four_channel_pwm_timer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // channel[1:0], duty[15:2], enable[16], zero[23:17]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // pwm_levels[3:0], count_value[19:4], update_event[20], zero[23:21]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CHN  = pwmt_pkg::CHANNELS;
    localparam int CW   = pwmt_pkg::CNT_W;
    localparam int MW   = pwmt_pkg::CMP_W;
    localparam int DW   = pwmt_pkg::DUTY_W;
    localparam int PW   = pwmt_pkg::PROD_W;
    localparam int SW   = pwmt_pkg::SCALED_W;

    // configuration
    logic [CW-1:0] prescale_limit_reg;
    logic [CW-1:0] period_limit_reg;

    // pipeline
    logic                v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic                ld1, ld2, ld3, ld4, ld5;
    pwmt_pkg::item_t     item1_reg, item2_reg, item3_reg, item4_reg;
    logic [DW-1:0]       duty1_reg;
    logic [PW-1:0]       prod2_reg, prod3_reg;
    logic [MW-1:0]       qest3_reg;
    logic [MW-1:0]       cmp4_reg;

    // timer state
    logic [CW-1:0]       presc_cnt_reg, presc_cnt_next;
    logic [CW-1:0]       main_cnt_reg, main_cnt_next;
    logic [MW-1:0]       shadow_reg [CHN];
    logic [MW-1:0]       shadow_next [CHN];
    logic [MW-1:0]       active_reg [CHN];
    logic [MW-1:0]       active_next [CHN];
    logic [CHN-1:0]      on_reg, on_next;
    logic [CHN-1:0]      levels_next;
    logic                upd_next;

    // output register
    logic [CHN-1:0]      levels_reg;
    logic [CW-1:0]       count_reg;
    logic                upd_reg;

    // stage arithmetic
    logic [DW-1:0]       duty_clamped;
    logic [MW-1:0]       period_plus;
    logic [PW-1:0]       prod_calc;
    logic [SW-1:0]       scaled;
    logic [PW-1:0]       back_mul;
    logic [PW-1:0]       rem;
    logic [MW-1:0]       cmp_calc;
    logic                apply;

    assign ld5      = !out_valid_reg || m_tready;
    assign ld4      = !v4_reg || ld5;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign s_tready = ld1;
    assign apply    = v4_reg && ld5;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, upd_reg, count_reg, levels_reg};

    always_comb
    begin
        duty_clamped = (duty1_reg > pwmt_pkg::DUTY_FULL) ? pwmt_pkg::DUTY_FULL : duty1_reg;
        period_plus  = {1'b0, period_limit_reg} + {{(MW-1){1'b0}}, 1'b1};
        prod_calc    = PW'(duty_clamped) * PW'(period_plus);
        scaled       = SW'(prod2_reg) * SW'(pwmt_pkg::DUTY_RECIP);
        back_mul     = PW'(qest3_reg) * PW'(pwmt_pkg::DUTY_FULL);
        rem          = prod3_reg - back_mul;
        cmp_calc     = (rem >= PW'(pwmt_pkg::DUTY_FULL)) ? qest3_reg + {{(MW-1){1'b0}}, 1'b1}
                                                        : qest3_reg;
    end

    always_comb
    begin
        presc_cnt_next = presc_cnt_reg;
        main_cnt_next  = main_cnt_reg;
        upd_next       = 1'b0;
        on_next        = on_reg;
        for (int i = 0; i < CHN; i++)
        begin
            shadow_next[i] = shadow_reg[i];
            active_next[i] = active_reg[i];
        end
        unique case (item4_reg.mode)
            pwmt_pkg::MODE_TICK:
            begin
                if (presc_cnt_reg >= prescale_limit_reg)
                begin
                    presc_cnt_next = '0;
                    if (main_cnt_reg >= period_limit_reg || main_cnt_reg == {CW{1'b1}})
                    begin
                        main_cnt_next = '0;
                        upd_next      = 1'b1;
                        for (int i = 0; i < CHN; i++)
                        begin
                            active_next[i] = shadow_reg[i];
                        end
                    end
                    else
                    begin
                        main_cnt_next = main_cnt_reg + {{(CW-1){1'b0}}, 1'b1};
                    end
                end
                else
                begin
                    presc_cnt_next = presc_cnt_reg + {{(CW-1){1'b0}}, 1'b1};
                end
            end
            pwmt_pkg::MODE_DUTY:
            begin
                if (int'(item4_reg.channel) < CHN)
                begin
                    shadow_next[item4_reg.channel] = cmp4_reg;
                end
            end
            pwmt_pkg::MODE_ENABLE:
            begin
                if (int'(item4_reg.channel) < CHN)
                begin
                    on_next[item4_reg.channel] = item4_reg.enable;
                end
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < CHN; i++)
        begin
            levels_next[i] = on_next[i] && ({1'b0, main_cnt_next} < active_next[i]);
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_limit_reg <= pwmt_pkg::PRESCALE_RESET;
            period_limit_reg   <= pwmt_pkg::PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (pwmt_pkg::cfg_index_t'(cfg_index))
                pwmt_pkg::CFG_PRESCALE: prescale_limit_reg <= cfg_data;
                pwmt_pkg::CFG_PERIOD:   period_limit_reg   <= cfg_data;
                default:                period_limit_reg   <= period_limit_reg;
            endcase
        end
    end

    // pipeline valids and timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            presc_cnt_reg <= '0;
            main_cnt_reg  <= '0;
            on_reg        <= '0;
            for (int i = 0; i < CHN; i++)
            begin
                shadow_reg[i] <= '0;
                active_reg[i] <= '0;
            end
        end
        else
        begin
            if (ld1) v1_reg <= s_tvalid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ld5) out_valid_reg <= v4_reg;
            if (apply)
            begin
                presc_cnt_reg <= presc_cnt_next;
                main_cnt_reg  <= main_cnt_next;
                on_reg        <= on_next;
                for (int i = 0; i < CHN; i++)
                begin
                    shadow_reg[i] <= shadow_next[i];
                    active_reg[i] <= active_next[i];
                end
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            item1_reg.mode    <= pwmt_pkg::mode_t'(s_tuser);
            item1_reg.channel <= s_tdata[1:0];
            item1_reg.enable  <= s_tdata[16];
            duty1_reg         <= s_tdata[15:2];
        end
        if (ld2)
        begin
            item2_reg <= item1_reg;
            prod2_reg <= prod_calc;
        end
        if (ld3)
        begin
            item3_reg <= item2_reg;
            prod3_reg <= prod2_reg;
            qest3_reg <= scaled[pwmt_pkg::RECIP_SHIFT +: MW];
        end
        if (ld4)
        begin
            item4_reg <= item3_reg;
            cmp4_reg  <= cmp_calc;
        end
        if (apply)
        begin
            levels_reg <= levels_next;
            count_reg  <= main_cnt_next;
            upd_reg    <= upd_next;
        end
    end

    // an update event always comes with the counter at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && upd_reg |-> count_reg == '0)
        else $error("update event with nonzero count");

    // a channel that is off never drives high
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (levels_reg & ~on_reg) == '0)
        else $error("level high on disabled channel");

    // timer state only moves when a request is applied
    assert property (@(posedge clk) disable iff (!rst_n)
        !apply |=> $stable(presc_cnt_reg) && $stable(main_cnt_reg) && $stable(on_reg))
        else $error("timer state changed without a request");

    // a stalled last stage keeps its compare
    assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !ld5 |=> v4_reg && $stable(cmp4_reg))
        else $error("stalled compare lost");

    // a wrap only happens on a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        apply && upd_next |-> item4_reg.mode == pwmt_pkg::MODE_TICK)
        else $error("update on non-tick request");

endmodule
